/* design/bounded_integer_list_engine_core_assert.svh */
// Assertion macros used by the list engine core.
`ifndef BOUNDED_INTEGER_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_INTEGER_LIST_ENGINE_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BILE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BILE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/bile_pkg.sv */
// Types and constants shared by the list engine modules.
package bile_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] K_APPEND    = 3'd0;
    localparam logic [2:0] K_READ      = 3'd1;
    localparam logic [2:0] K_OVERWRITE = 3'd2;
    localparam logic [2:0] K_FIND      = 3'd3;
    localparam logic [2:0] K_COUNT     = 3'd4;
    localparam logic [2:0] K_DELETE    = 3'd5;
    localparam logic [2:0] K_CLEAR     = 3'd6;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]               kind;
        logic [3:0]               position;
        logic signed [DATA_W-1:0] operand_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [3:0]               found_position;
        logic [4:0]               match_count;
        logic [1:0]               status;
        logic [4:0]               length_after;
    } t_res;

    typedef struct packed {
        logic wr;
        logic take_next;
    } t_cell_ctl;

endpackage

/* design/bile_cell.sv */
// One list entry cell that loads a new word or takes its neighbor's word.
module bile_cell (
    input  logic                              i_clk,
    input  bile_pkg::t_cell_ctl               i_ctl,
    input  logic signed [bile_pkg::DATA_W-1:0] i_wdata,
    input  logic signed [bile_pkg::DATA_W-1:0] i_next,
    output logic signed [bile_pkg::DATA_W-1:0] o_val
);
    import bile_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.take_next) begin
            n_val = i_next;
        end else if (i_ctl.wr) begin
            n_val = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

/* design/bounded_integer_list_engine_core.sv */
// Top level of the list engine: a row of entry cells and the request sequencer.
// Append, read, overwrite, delete, clear: result next cycle; one word per cycle unless busy.
// Find and count rotate the cell ring once while busy; the result is strobed as busy drops.
// The scan rate is set by the single comparator at the head cell of the ring.
// Synchronous active-low reset empties the list and clears the control state.
// Results are strobed for one cycle and the receiver cannot stall them.
`include "bounded_integer_list_engine_core_assert.svh"

module bounded_integer_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bile_pkg::t_req i_req,
    output logic           o_res_valid,
    output bile_pkg::t_res o_res
);
    import bile_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int NR = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int LW = (NR > 1) ? $clog2(NR) : 1;
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [SW-1:0]            r_step, n_step;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_is_find, n_is_find;
    logic                     r_fnd, n_fnd;
    logic [3:0]               r_fpos, n_fpos;
    logic [CW-1:0]            r_cnt, n_cnt;
    t_res                     r_res, n_res;
    logic                     r_strobe, n_strobe;

    logic signed [DATA_W-1:0] w_cell_val [CAPACITY];
    t_cell_ctl                w_ctl [CAPACITY];
    logic signed [DATA_W-1:0] w_low [NR];
    logic signed [DATA_W-1:0] w_rd_old;
    logic                     w_accept;
    logic                     w_pos_ok;
    logic                     w_full;
    logic                     w_hit;
    logic                     w_scan;

    assign busy     = (r_state == ST_SCAN);
    assign w_scan   = (r_state == ST_SCAN);
    assign w_accept = start && !busy;
    assign w_pos_ok = PW'(i_req.position) < PW'(r_count);
    assign w_full   = (r_count == CAP_C);
    assign w_hit    = (CW'(r_step) < r_count) && (w_cell_val[0] == r_key);

    genvar gi;
    generate
        for (gi = 0; gi < NR; gi++) begin : g_low
            assign w_low[gi] = w_cell_val[gi];
        end

        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_next;
            logic                     w_del_shift;

            if (gi < CAPACITY - 1) begin : g_mid
                assign w_next      = w_cell_val[gi+1];
                assign w_del_shift = w_accept && (i_req.kind == K_DELETE) && w_pos_ok
                                     && (PW'(gi) >= PW'(i_req.position));
            end else begin : g_last
                assign w_next      = w_cell_val[0];
                assign w_del_shift = 1'b0;
            end

            assign w_ctl[gi].take_next = w_scan || w_del_shift;
            assign w_ctl[gi].wr = w_accept
                && (((i_req.kind == K_APPEND) && !w_full && (r_count == CW'(gi)))
                 || ((i_req.kind == K_OVERWRITE) && w_pos_ok
                     && (PW'(i_req.position) == PW'(gi))));

            bile_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[gi]),
                .i_wdata (i_req.operand_value),
                .i_next  (w_next),
                .o_val   (w_cell_val[gi])
            );
        end
    endgenerate

    assign w_rd_old = w_low[LW'(i_req.position)];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_step    = r_step;
        n_key     = r_key;
        n_is_find = r_is_find;
        n_fnd     = r_fnd;
        n_fpos    = r_fpos;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_strobe  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res    = '0;
                    n_strobe = 1'b1;
                    unique case (i_req.kind)
                        K_APPEND: begin
                            if (w_full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        K_READ, K_OVERWRITE: begin
                            if (w_pos_ok) begin
                                n_res.read_value = w_rd_old;
                            end else begin
                                n_res.status = STAT_RANGE;
                            end
                        end
                        K_FIND, K_COUNT: begin
                            n_strobe  = 1'b0;
                            n_state   = ST_SCAN;
                            n_step    = '0;
                            n_key     = i_req.operand_value;
                            n_is_find = (i_req.kind == K_FIND);
                            n_fnd     = 1'b0;
                            n_fpos    = '0;
                            n_cnt     = '0;
                        end
                        K_DELETE: begin
                            if (w_pos_ok) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_res.status = STAT_RANGE;
                            end
                        end
                        K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.length_after = 5'(n_count);
                end
            end
            ST_SCAN: begin
                n_step = r_step + SW'(1);
                if (w_hit) begin
                    n_cnt = r_cnt + CW'(1);
                    if (!r_fnd) begin
                        n_fnd  = 1'b1;
                        n_fpos = 4'(r_step);
                    end
                end
                if (r_step == LAST_STEP) begin
                    n_state            = ST_IDLE;
                    n_strobe           = 1'b1;
                    n_res              = '0;
                    n_res.length_after = 5'(r_count);
                    if (r_is_find) begin
                        n_res.found          = n_fnd;
                        n_res.found_position = n_fpos;
                    end else begin
                        n_res.match_count = 5'(n_cnt);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_is_find <= n_is_find;
        r_fnd     <= n_fnd;
        r_fpos    <= n_fpos;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
    end

    assign o_res_valid = r_strobe;
    assign o_res       = r_res;

    `BILE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CAP_C, "list length above capacity")
    `BILE_ASSERT_NEXT(a_scan_done, w_scan && (r_step == LAST_STEP), o_res_valid && !busy, "scan end without result")
    `BILE_ASSERT_NEXT(a_scan_start, w_accept && ((i_req.kind == K_FIND) || (i_req.kind == K_COUNT)), busy && !o_res_valid, "search did not enter scan")
    `BILE_ASSERT_NEXT(a_direct_done, w_accept && (i_req.kind != K_FIND) && (i_req.kind != K_COUNT), o_res_valid && !busy, "direct request without result")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded integer list engine core.
module tb;
    import bile_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic [2:0] K_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MODE_MIXED = 0;
    localparam int MODE_CHURN = 1;
    localparam int MODE_NOISE = 2;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_res_valid;
    t_res o_res;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    logic [4:0] list_len;
    t_res awaited_list_results [$];
    logic [DATA_W-1:0] value_pool [8];
    bit idle_free = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bounded_integer_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_res_valid(o_res_valid),
        .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_res apply_list_request(input t_req rq);
        t_res r;
        int i;
        logic pos_ok;
        r = '0;
        pos_ok = (rq.position < list_len);
        case (rq.kind)
            K_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    list_mem[list_len] = rq.operand_value;
                    list_len = list_len + 5'd1;
                end
            end
            K_READ: begin
                if (pos_ok) begin
                    r.read_value = list_mem[rq.position];
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            K_OVERWRITE: begin
                if (pos_ok) begin
                    r.read_value = list_mem[rq.position];
                    list_mem[rq.position] = rq.operand_value;
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            K_FIND: begin
                for (i = 0; i < list_len; i++) begin
                    if (!r.found && list_mem[i] == rq.operand_value) begin
                        r.found = 1'b1;
                        r.found_position = 4'(i);
                    end
                end
            end
            K_COUNT: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == rq.operand_value) begin
                        r.match_count = r.match_count + 5'd1;
                    end
                end
            end
            K_DELETE: begin
                if (pos_ok) begin
                    for (i = rq.position; i + 1 < list_len; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_len = list_len - 5'd1;
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            K_CLEAR: begin
                list_len = '0;
            end
            default: begin
            end
        endcase
        r.length_after = list_len;
        return r;
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [3:0] pos,
                                      input logic [DATA_W-1:0] val);
        t_req r;
        r.kind = kind;
        r.position = pos;
        r.operand_value = val;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 70) begin
            return value_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_position();
        if (list_len != 0 && $urandom_range(9) < 8) begin
            return 4'($urandom_range(int'(list_len) - 1));
        end
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [2:0] pick_kind(input int mode);
        int r;
        r = $urandom_range(99);
        if (mode == MODE_MIXED) begin
            if (r < 30) return K_APPEND;
            if (r < 42) return K_READ;
            if (r < 54) return K_OVERWRITE;
            if (r < 66) return K_FIND;
            if (r < 78) return K_COUNT;
            if (r < 93) return K_DELETE;
            if (r < 98) return K_CLEAR;
            return K_UNUSED;
        end
        if (r < 35) return K_APPEND;
        if (r < 45) return K_READ;
        if (r < 55) return K_OVERWRITE;
        if (r < 65) return K_FIND;
        if (r < 75) return K_COUNT;
        if (r < 99) return K_DELETE;
        return K_CLEAR;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (awaited_list_results.size() == 0) begin
                report_mismatch("unrequested result word, length_after", 32'(o_res.length_after),
                                '0);
            end else begin
                want = awaited_list_results.pop_front();
                check_field("read_value", o_res.read_value, want.read_value);
                check_field("found", 32'(o_res.found), 32'(want.found));
                check_field("found_position", 32'(o_res.found_position),
                            32'(want.found_position));
                check_field("match_count", 32'(o_res.match_count), 32'(want.match_count));
                check_field("status", 32'(o_res.status), 32'(want.status));
                check_field("length_after", 32'(o_res.length_after), 32'(want.length_after));
            end
        end
    end

    task automatic send_word(input t_req rq);
        int gap;
        gap = idle_free ? 0 : $urandom_range(19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        awaited_list_results.push_back(apply_list_request(rq));
    endtask

    task automatic wait_until_drained();
        while (awaited_list_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_word(make_req(K_READ, 4'd0, 32'h0));
        send_word(make_req(K_FIND, 4'd0, 32'h0));
    endtask

    task automatic test_fill_to_capacity();
        int i;
        logic [DATA_W-1:0] val;
        for (i = 0; i < CAPACITY; i++) begin
            case (i)
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2, 4: val = 32'hFFFF_FFFF;
                3: val = 32'h0;
                default: val = $urandom;
            endcase
            send_word(make_req(K_APPEND, 4'($urandom_range(15)), val));
        end
        send_word(make_req(K_APPEND, 4'd0, 32'h1234_5678));
    endtask

    task automatic test_full_list_ops();
        send_word(make_req(K_READ, 4'd15, 32'h0));
        send_word(make_req(K_OVERWRITE, 4'd0, 32'h7FFF_FFFF));
        send_word(make_req(K_FIND, 4'd0, 32'hFFFF_FFFF));
        send_word(make_req(K_COUNT, 4'd0, 32'h7FFF_FFFF));
        send_word(make_req(K_DELETE, 4'd3, 32'h0));
        send_word(make_req(K_DELETE, 4'd15, 32'h0));
        send_word(make_req(K_UNUSED, 4'hF, 32'hFFFF_FFFF));
        send_word(make_req(K_CLEAR, 4'd0, 32'h0));
        send_word(make_req(K_READ, 4'd0, 32'h0));
    endtask

    task automatic run_random(input int count, input int mode);
        int k;
        t_req rq;
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0) begin
                idle_free = ($urandom_range(3) == 0);
            end
            if (mode == MODE_NOISE) begin
                rq = make_req(3'($urandom_range(7)), 4'($urandom_range(15)), $urandom);
            end else begin
                rq = make_req(pick_kind(mode), pick_position(), pick_value());
            end
            send_word(rq);
        end
        idle_free = 1'b0;
    endtask

    task automatic test_random_mixed();
        run_random(900, MODE_MIXED);
    endtask

    task automatic test_random_churn();
        run_random(900, MODE_CHURN);
    endtask

    task automatic test_random_noise();
        run_random(150, MODE_NOISE);
    endtask

    initial begin
        int j;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0;
        for (j = 4; j < 8; j++) begin
            value_pool[j] = $urandom;
        end
        for (j = 0; j < CAPACITY; j++) begin
            list_mem[j] = '0;
        end
        list_len = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_fill_to_capacity();
        test_full_list_ops();
        test_random_mixed();
        start <= 1'b0;
        wait_until_drained();
        test_random_churn();
        test_random_noise();
        start <= 1'b0;
        wait_until_drained();
        repeat (CAPACITY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* bounded_integer_list_engine_core.f */
+incdir+design
design/bile_pkg.sv
design/bile_cell.sv
design/bounded_integer_list_engine_core.sv
bench/tb.sv
